/* rtl/crce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_pkg
// Shared types and constants of the bit-serial CRC frame encoder.
// ----------------------------------------------------------------------------
package crce_pkg;

  localparam int POLY_W       = 33;
  localparam int GEN_LEN_W    = 6;
  localparam int FRAME_LEN_W  = 16;
  localparam int CFG_DATA_W   = 33;
  localparam int CFG_INDEX_W  = 2;
  localparam int GLEN_W       = 7;
  localparam int DEF_MAX_GEN_LEN = 33;
  localparam int DEF_COUNT_BITS  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_POLY      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GEN_LEN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LEN = 2'd2;

  localparam logic [POLY_W-1:0]      POLY_RST      = 33'h0_0001_1021;
  localparam logic [GEN_LEN_W-1:0]   GEN_LEN_RST   = 6'd17;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 16'd256;

  typedef struct packed {
    logic step;
    logic unload;
    logic feedback;
  } cell_ctrl_t;

  typedef struct packed {
    logic out_bit;
    logic is_check;
    logic last_of_frame;
  } result_t;

endpackage

/* rtl/bitwise_crc_frame_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitwise_crc_frame_encoder_core
// Bit-serial CRC frame encoder with configurable generator and frame length.
//
// Frame bits enter on in_data_bit under in_valid/in_stall, one per cycle.
// Each bit is shifted through a row of remainder cells with generator feedback.
// The leading frame_length-gen_length+1 bits are passed to the output channel
// (out_bit, out_is_check, out_last_of_frame). The tail bits give no output.
// The frame's last bit loads the final remainder, which is then shifted out of
// the same cell row MSB first, one bit per cycle while the skid entry is empty,
// the last one flagged. During that unload of gen_length-1 check bits, in_stall
// is high. The output channel has a register and a skid entry; a stalled
// receiver fills the skid entry and then raises in_stall.
// Reset (rst_n low, synchronous) clears the remainder and bit counter, empties
// the output stage and restores poly 0x11021, gen_length 17, frame_length 256.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do
// so only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module bitwise_crc_frame_encoder_core #(
  parameter int MAX_GEN_LEN = crce_pkg::DEF_MAX_GEN_LEN,
  parameter int COUNT_BITS  = crce_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_data_bit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_bit,
  output logic                             out_is_check,
  output logic                             out_last_of_frame,
  input  logic                             cfg_we,
  input  logic [crce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crce_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW    = MAX_GEN_LEN - 1;
  localparam int CMP_W = ((COUNT_BITS > crce_pkg::FRAME_LEN_W) ?
                          COUNT_BITS : crce_pkg::FRAME_LEN_W) + 1;
  localparam int GW    = crce_pkg::GLEN_W;

  logic [crce_pkg::POLY_W-1:0]      poly_r, poly_nxt;
  logic [crce_pkg::GEN_LEN_W-1:0]   gen_len_r, gen_len_nxt;
  logic [crce_pkg::FRAME_LEN_W-1:0] frame_len_r, frame_len_nxt;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  unload_r, unload_nxt;
  logic [GW-1:0]         rem_r, rem_nxt;

  logic [GW-1:0]    gen_raw, gen_eff;
  logic [CMP_W-1:0] gen_ext, flen_ext, flen_eff, cnt_ext;
  logic             last_bit, pass_bit, step, skid_full, shift_out, top;

  logic [CW-1:0] cell_q, cell_top, cell_poly;
  logic          chain_in;

  crce_pkg::cell_ctrl_t ctrl;
  crce_pkg::result_t    up_res, out_res;
  logic                 up_valid;

  // configuration
  always_comb begin
    poly_nxt      = poly_r;
    gen_len_nxt   = gen_len_r;
    frame_len_nxt = frame_len_r;
    if (cfg_we) begin
      unique case (cfg_index)
        crce_pkg::CFG_POLY:      poly_nxt      = cfg_data;
        crce_pkg::CFG_GEN_LEN:   gen_len_nxt   = cfg_data[crce_pkg::GEN_LEN_W-1:0];
        crce_pkg::CFG_FRAME_LEN: frame_len_nxt = cfg_data[crce_pkg::FRAME_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths
  assign gen_raw = GW'(gen_len_r);
  always_comb begin
    gen_eff = gen_raw;
    if (gen_raw < GW'(2)) begin
      gen_eff = GW'(2);
    end else if (gen_raw > GW'(MAX_GEN_LEN)) begin
      gen_eff = GW'(MAX_GEN_LEN);
    end
  end

  assign gen_ext  = CMP_W'(gen_eff);
  assign flen_ext = CMP_W'(frame_len_r);
  assign flen_eff = (flen_ext < gen_ext) ? gen_ext : flen_ext;
  assign cnt_ext  = CMP_W'(cnt_r);
  assign last_bit = cnt_ext >= (flen_eff - CMP_W'(1));
  assign pass_bit = cnt_ext < (flen_eff - gen_ext + CMP_W'(1));

  assign in_stall  = unload_r || skid_full;
  assign step      = in_valid && !in_stall;
  assign shift_out = unload_r && !skid_full;

  // frame control
  always_comb begin
    cnt_nxt    = cnt_r;
    unload_nxt = unload_r;
    rem_nxt    = rem_r;
    if (step) begin
      if (last_bit) begin
        cnt_nxt    = '0;
        unload_nxt = 1'b1;
        rem_nxt    = gen_eff - GW'(1);
      end else begin
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end else if (shift_out) begin
      rem_nxt = rem_r - GW'(1);
      if (rem_r == GW'(1)) begin
        unload_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= crce_pkg::POLY_RST;
      gen_len_r   <= crce_pkg::GEN_LEN_RST;
      frame_len_r <= crce_pkg::FRAME_LEN_RST;
      cnt_r       <= '0;
      unload_r    <= 1'b0;
      rem_r       <= '0;
    end else begin
      poly_r      <= poly_nxt;
      gen_len_r   <= gen_len_nxt;
      frame_len_r <= frame_len_nxt;
      cnt_r       <= cnt_nxt;
      unload_r    <= unload_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // remainder cell row
  assign top           = |(cell_q & cell_top);
  assign chain_in      = step & in_data_bit;
  assign ctrl.step     = step;
  assign ctrl.unload   = shift_out;
  assign ctrl.feedback = top;

  for (genvar i = 0; i < CW; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = chain_in;
    end else begin : g_link
      assign prev = cell_q[i-1];
    end
    if (i < crce_pkg::POLY_W) begin : g_poly
      assign cell_poly[i] = poly_r[i];
    end else begin : g_nopoly
      assign cell_poly[i] = 1'b0;
    end
    crce_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .gen_eff  (gen_eff),
      .poly_bit (cell_poly[i]),
      .prev_bit (prev),
      .q        (cell_q[i]),
      .is_top   (cell_top[i])
    );
  end

  // result transaction
  assign up_valid = (step && pass_bit && !last_bit) || shift_out;
  always_comb begin
    if (shift_out) begin
      up_res.out_bit       = top;
      up_res.is_check      = 1'b1;
      up_res.last_of_frame = rem_r == GW'(1);
    end else begin
      up_res.out_bit       = in_data_bit;
      up_res.is_check      = 1'b0;
      up_res.last_of_frame = 1'b0;
    end
  end

  crce_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (up_valid),
    .up_res    (up_res),
    .up_stall  (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_bit           = out_res.out_bit;
  assign out_is_check      = out_res.is_check;
  assign out_last_of_frame = out_res.last_of_frame;

  a_last_starts_unload: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_bit) |=> (unload_r && cnt_r == '0))
    else $error("frame end did not start remainder unload");

  a_unload_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (shift_out && rem_r == GW'(1)) |=> !unload_r)
    else $error("unload did not end after final check bit");

  a_unload_count: assert property (@(posedge clk) disable iff (!rst_n)
    unload_r |-> (rem_r != '0))
    else $error("unload active with no bits left");

  a_no_step_in_unload: assert property (@(posedge clk) disable iff (!rst_n)
    unload_r |-> !step)
    else $error("transaction accepted during remainder unload");

endmodule

/* rtl/crce_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_cell
// One remainder bit: shift with generator feedback, or plain shift on unload.
// ----------------------------------------------------------------------------
module crce_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crce_pkg::cell_ctrl_t         ctrl,
  input  logic [crce_pkg::GLEN_W-1:0]  gen_eff,
  input  logic                         poly_bit,
  input  logic                         prev_bit,
  output logic                         q,
  output logic                         is_top
);

  logic q_r;
  logic q_nxt;
  logic in_width;

  assign in_width = gen_eff > crce_pkg::GLEN_W'(IDX + 1);
  assign is_top   = gen_eff == crce_pkg::GLEN_W'(IDX + 2);

  always_comb begin
    q_nxt = q_r;
    if (ctrl.step) begin
      q_nxt = in_width & (prev_bit ^ (poly_bit & ctrl.feedback));
    end else if (ctrl.unload) begin
      q_nxt = in_width & prev_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/crce_out_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_out_skid
// Output register with a skid entry; upstream stall is registered.
// ----------------------------------------------------------------------------
module crce_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  crce_pkg::result_t  up_res,
  output logic               up_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output crce_pkg::result_t  out_res
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_full_r, skid_full_nxt;
  crce_pkg::result_t out_res_r, out_res_nxt;
  crce_pkg::result_t skid_r, skid_nxt;
  logic              out_ready;

  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_res_nxt   = out_res_r;
    skid_nxt      = skid_r;
    if (skid_full_r) begin
      if (!out_stall) begin
        out_res_nxt   = skid_r;
        out_valid_nxt = 1'b1;
        skid_full_nxt = 1'b0;
      end
    end else if (up_valid) begin
      if (out_ready) begin
        out_res_nxt   = up_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt      = up_res;
        skid_full_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
    out_res_r <= out_res_nxt;
    skid_r    <= skid_nxt;
  end

  assign up_stall  = skid_full_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
